@@ rtl/vnf_pkg.sv @@
// ----------------------------------------------------------------------------
// vnf_pkg: shared types and constants for the fractal value noise block
// Hash multipliers, Q0.16 unit and the word carried between octave cells.
// ----------------------------------------------------------------------------
package vnf_pkg;

  localparam int          CNT_W      = 4;
  localparam logic [3:0]  OCT_RESET  = 4'd3;
  localparam logic [31:0] HASH_KX    = 32'd374761393;
  localparam logic [31:0] HASH_KY    = 32'd668265263;
  localparam logic [31:0] HASH_KMIX  = 32'd1274126177;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [17:0] THREE_Q16  = 18'd196608;

  // Word that travels down the row of octave cells.
  typedef struct packed {
    logic        valid;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
    logic [31:0] acc;     // Q0.32 running sum
  } vnf_word_t;

endpackage

@@ rtl/vnf_cell.sv @@
// ----------------------------------------------------------------------------
// vnf_cell: one octave of value noise
// Six-stage pipeline: split, hash and ease products, hash mix, blend, sum.
// ----------------------------------------------------------------------------
module vnf_cell #(
  parameter int OCT       = 0,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [3:0]              oct_cnt,
  input  vnf_pkg::vnf_word_t      word_in,
  output vnf_pkg::vnf_word_t      word_out
);
  import vnf_pkg::*;

  localparam int DLY = 5;

  // Split of the scaled point.
  logic signed [63:0] sx, sy;
  logic [FRAC_BITS+15:0] fxw, fyw;
  assign sx  = $signed({{32{word_in.x_coord[31]}}, word_in.x_coord}) <<< OCT;
  assign sy  = $signed({{32{word_in.y_coord[31]}}, word_in.y_coord}) <<< OCT;
  assign fxw = {sx[FRAC_BITS-1:0], 16'b0};
  assign fyw = {sy[FRAC_BITS-1:0], 16'b0};

  // Word delay line alongside the arithmetic.
  vnf_word_t dly_r [DLY];

  logic [31:0] cx_r, cy_r;
  logic [15:0] fx_r, fy_r, fx2_r, fy2_r;
  logic [31:0] px0_r, px1_r, py0_r, py1_r, ttx_r, tty_r;
  logic [31:0] g_r [4];
  logic [15:0] u_r, v_r, u4_r, v4_r, v5_r;
  logic [31:0] p_r [4];
  logic [15:0] ab_r, cd_r;
  vnf_word_t   out_r;

  logic [31:0] h0 [4];
  logic [49:0] ex, ey;
  logic [31:0] pf [4];
  logic [15:0] cv [4];
  logic [32:0] bab, bcd, bfin;
  logic [31:0] add_term;

  always_comb begin
    h0[0] = px0_r + py0_r;
    h0[1] = px1_r + py0_r;
    h0[2] = px0_r + py1_r;
    h0[3] = px1_r + py1_r;
    ex = 50'(ttx_r) * 50'(THREE_Q16 - {1'b0, fx2_r, 1'b0});
    ey = 50'(tty_r) * 50'(THREE_Q16 - {1'b0, fy2_r, 1'b0});
    for (int k = 0; k < 4; k++) begin
      pf[k] = p_r[k] ^ (p_r[k] >> 16);
      cv[k] = pf[k][15:0];
    end
    bab  = 33'(cv[0]) * 33'(ONE_Q16 - {1'b0, u4_r}) + 33'(cv[1]) * 33'(u4_r);
    bcd  = 33'(cv[2]) * 33'(ONE_Q16 - {1'b0, u4_r}) + 33'(cv[3]) * 33'(u4_r);
    bfin = 33'(ab_r) * 33'(ONE_Q16 - {1'b0, v5_r}) + 33'(cd_r) * 33'(v5_r);
    add_term = (32'(OCT) < 32'(oct_cnt)) ? (32'(bfin[31:16]) << (15 - OCT)) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DLY; s++) begin
        dly_r[s].valid <= 1'b0;
      end
      out_r.valid <= 1'b0;
    end else if (en) begin
      dly_r[0].valid <= word_in.valid;
      for (int s = 1; s < DLY; s++) begin
        dly_r[s].valid <= dly_r[s-1].valid;
      end
      out_r.valid <= dly_r[DLY-1].valid;
    end
    if (en) begin
      cx_r  <= sx[FRAC_BITS+31:FRAC_BITS];
      cy_r  <= sy[FRAC_BITS+31:FRAC_BITS];
      fx_r  <= fxw[FRAC_BITS+15:FRAC_BITS];
      fy_r  <= fyw[FRAC_BITS+15:FRAC_BITS];
      px0_r <= cx_r * HASH_KX;
      px1_r <= (cx_r + 32'd1) * HASH_KX;
      py0_r <= cy_r * HASH_KY;
      py1_r <= (cy_r + 32'd1) * HASH_KY;
      ttx_r <= 32'(fx_r) * 32'(fx_r);
      tty_r <= 32'(fy_r) * 32'(fy_r);
      fx2_r <= fx_r;
      fy2_r <= fy_r;
      for (int k = 0; k < 4; k++) begin
        g_r[k] <= h0[k] ^ (h0[k] >> 13);
        p_r[k] <= g_r[k] * HASH_KMIX;
      end
      u_r   <= ex[47:32];
      v_r   <= ey[47:32];
      u4_r  <= u_r;
      v4_r  <= v_r;
      ab_r  <= bab[31:16];
      cd_r  <= bcd[31:16];
      v5_r  <= v4_r;
      dly_r[0].x_coord <= word_in.x_coord;
      dly_r[0].y_coord <= word_in.y_coord;
      dly_r[0].acc     <= word_in.acc;
      for (int s = 1; s < DLY; s++) begin
        dly_r[s].x_coord <= dly_r[s-1].x_coord;
        dly_r[s].y_coord <= dly_r[s-1].y_coord;
        dly_r[s].acc     <= dly_r[s-1].acc;
      end
      out_r.x_coord <= dly_r[DLY-1].x_coord;
      out_r.y_coord <= dly_r[DLY-1].y_coord;
      out_r.acc     <= dly_r[DLY-1].acc + add_term;
    end
  end

  assign word_out = out_r;

endmodule

@@ rtl/value_noise_fbm.sv @@
// An accepted input word passes each octave cell, then the output register.
// Throughput: one word per cycle unless stalled; each cell is a six-stage
// pipeline, the row advances together, so the slowest stage is one multiply.
// Reset: synchronous active-low rst_n clears all valid bits, including those of
// the output buffers, and sets oct_cnt_r to 3. No clearing pass is needed.
// ----------------------------------------------------------------------------
// value_noise_fbm: fractal 2-D value noise, one sample per cycle
// A row of octave cells; cell i < octave count adds octave i into a Q0.32
// sum riding with the coordinates. A two-entry output buffer decouples stalls.
// ----------------------------------------------------------------------------
module value_noise_fbm #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_coord,
  input  logic [31:0] in_y_coord,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_noise_value
);
  import vnf_pkg::*;

  // The octave count register; counts above MAX_OCTAVES saturate.
  logic [CNT_W-1:0] oct_cnt_r;
  logic [CNT_W-1:0] oct_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r <= OCT_RESET;
    end else if (cfg_wr_en) begin
      oct_cnt_r <= cfg_wr_data;
    end
  end

  assign oct_sat = (32'(oct_cnt_r) > MAX_OCTAVES) ? CNT_W'(MAX_OCTAVES) : oct_cnt_r;

  // The whole row moves whenever the skid slot is empty. A word leaving the
  // row then always has a place: the output register or the skid slot.
  logic en;
  logic skid_valid_r;
  logic [15:0] skid_data_r;
  logic out_valid_r;
  logic [15:0] out_data_r;

  assign en = !skid_valid_r;

  vnf_word_t chain [MAX_OCTAVES+1];

  assign chain[0].valid   = in_valid && !in_stall;
  assign chain[0].x_coord = in_x_coord;
  assign chain[0].y_coord = in_y_coord;
  assign chain[0].acc     = 32'd0;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    vnf_cell #(
      .OCT       (g),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .oct_cnt  (oct_sat),
      .word_in  (chain[g]),
      .word_out (chain[g+1])
    );
  end

  logic tail_valid;
  logic [15:0] tail_data;
  logic take;

  assign tail_valid = chain[MAX_OCTAVES].valid && en;
  assign tail_data  = chain[MAX_OCTAVES].acc[31:16];
  assign take       = out_valid_r && !out_stall;

  // Output register with one skid slot behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= tail_valid;
      end
    end else if (tail_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : tail_data;
    end else if (tail_valid) begin
      skid_data_r <= tail_data;
    end
  end

  assign in_stall        = skid_valid_r;
  assign out_valid       = out_valid_r;
  assign out_noise_value = out_data_r;

  // The skid slot only fills behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while output register empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid slot filled without a stalled output word");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> !skid_valid_r && out_valid_r)
    else $error("skid slot did not drain into the output register");

endmodule

@@ bench/vnf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnf_checker: scoreboard for the fractal value noise block
// Watches both channels, computes the expected noise for every accepted word
// and compares it against the words that leave the block, oldest first.
// ----------------------------------------------------------------------------
module vnf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_x_coord,
  input  logic [31:0] in_y_coord,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_noise_value,
  output int          fail_count,
  output int          pending
);
  import vnf_pkg::*;

  localparam int MAX_OCT = 8;
  localparam int FRAC    = 16;

  logic [3:0]  octaves;
  logic [15:0] noise_expected[$];

  function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] h;
    h = cx * HASH_KX + cy * HASH_KY;
    h = (h ^ (h >> 13)) * HASH_KMIX;
    return (h ^ (h >> 16)) & 32'hFFFF;
  endfunction

  function automatic logic [31:0] smooth_weight(logic [31:0] t);
    logic [63:0] tt, k;
    tt = 64'(t) * 64'(t);
    k  = 64'd196608 - 64'(t) * 64'd2;
    return 32'((tt * k) >> 32);
  endfunction

  function automatic logic [31:0] mix(logic [31:0] a, logic [31:0] b, logic [31:0] w);
    logic [63:0] r;
    r = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w);
    return 32'(r >> 16);
  endfunction

  function automatic logic [15:0] fbm_noise(logic [31:0] xc, logic [31:0] yc,
                                            logic [3:0] cnt);
    logic [63:0] sx, sy, acc;
    logic [31:0] cx, cy, fx, fy, u, v, ab, cd, n;
    int lim;
    acc = '0;
    lim = (cnt > MAX_OCT) ? MAX_OCT : cnt;
    for (int i = 0; i < lim; i++) begin
      // Arithmetic shift of the sign-extended point keeps floor semantics.
      sx = {{32{xc[31]}}, xc} << i;
      sy = {{32{yc[31]}}, yc} << i;
      cx = 32'($signed(sx) >>> FRAC);
      cy = 32'($signed(sy) >>> FRAC);
      fx = 32'(sx[FRAC-1:0]);
      fy = 32'(sy[FRAC-1:0]);
      u  = smooth_weight(fx);
      v  = smooth_weight(fy);
      ab = mix(lattice_hash(cx, cy), lattice_hash(cx + 1, cy), u);
      cd = mix(lattice_hash(cx, cy + 1), lattice_hash(cx + 1, cy + 1), u);
      n  = mix(ab, cd, v);
      acc += 64'(n) << (15 - i);
    end
    return 16'(acc >> 16);
  endfunction

  assign pending = noise_expected.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      octaves <= OCT_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) octaves <= cfg_wr_data;
      if (in_valid && !in_stall)
        noise_expected.push_back(fbm_noise(in_x_coord, in_y_coord, octaves));
      if (out_valid && !out_stall) begin
        if (noise_expected.size() == 0) begin
          $error("unexpected word: noise_value actual %0d", out_noise_value);
          fail_count <= fail_count + 1;
        end else begin
          logic [15:0] e;
          e = noise_expected.pop_front();
          if (e !== out_noise_value) begin
            $error("noise_value mismatch: expected %0d actual %0d", e, out_noise_value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ bench/tb_value_noise_fbm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_value_noise_fbm: stimulus and verdict for the fractal value noise block
// Sweeps the octave count over values from 0 to 15, drives directed corner
// points then random points, and lets the checker score every output word.
// ----------------------------------------------------------------------------
module tb_value_noise_fbm;
  import vnf_pkg::*;

  localparam int LATENCY   = 6 * 8 + 1;
  localparam int WD_LIMIT  = 2000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [3:0]  cfg_wr_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_x_coord = '0;
  logic [31:0] in_y_coord = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] out_noise_value;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          quiet_mode = 0;   // no idling on either side
  bit          hold_off = 0;     // receiver holds off for a long stretch
  bit          timed_out = 0;

  value_noise_fbm u_dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_stall, .in_x_coord, .in_y_coord,
    .out_valid, .out_stall, .out_noise_value
  );

  vnf_checker u_checker (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_stall, .in_x_coord, .in_y_coord,
    .out_valid, .out_stall, .out_noise_value,
    .fail_count, .pending
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The receiver stalls in about 19 percent of cycles, except in quiet mode.
  // During a hold-off it stalls without a break so the pipeline backs up.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (quiet_mode) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 19);
  end

  // The watchdog counts cycles in which neither channel moves a word, outside hold-off and reset.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("value_noise_fbm test failed");
      $finish;
    end
  end

  // Offers one word and holds it until the block accepts it. Valid stays high
  // across back-to-back words, so it is only written once per step.
  task automatic send_word(logic [31:0] xc, logic [31:0] yc);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 19) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_x_coord <= xc;
    in_y_coord <= yc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Register writes only happen once the pipeline has drained.
  task automatic set_octaves(logic [3:0] cnt);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cnt;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] random_point();
    case ($urandom_range(3))
      0: return $urandom();                                  // anywhere
      1: return 32'($signed($urandom_range(2097152)) - 1048576); // near origin
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return {16'($urandom()), $urandom_range(1) ? 16'hFFFF : 16'h0000};
    endcase
  endfunction

  logic [31:0] corners[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h0000_FFFF, 32'hFFFF_0000,
                              32'h0001_0000, 32'h5555_AAAA};
  logic [3:0]  sweep[8] = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd9, 4'd3, 4'd5, 4'd2};

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed points at the reset octave count: sign, carry and fraction edges.
    for (int i = 0; i < 8; i++) send_word(corners[i], corners[7 - i]);
    for (int i = 0; i < 8; i++) send_word(corners[i], corners[i]);

    // Octave settings including zero, saturation above the maximum and
    // the extremes of the register; each phase gets random points.
    for (int p = 0; p < 8; p++) begin
      set_octaves(sweep[p]);
      quiet_mode = (p == 3);
      if (p == 4) begin
        // Long receiver hold-off while the sender keeps offering words.
        fork
          begin
            hold_off = 1;
            repeat (300) @(negedge clk);
            hold_off = 0;
          end
          for (int i = 0; i < 80; i++) send_word(random_point(), random_point());
        join
      end
      for (int i = 0; i < 65; i++) send_word(random_point(), random_point());
      send_word(corners[p], corners[(p + 3) % 8]);
    end
    quiet_mode = 0;
    in_valid <= 1'b0;

    fork
      begin
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
      end
      begin
        repeat (20000) @(negedge clk);
        timed_out = 1;
      end
    join_any
    if (timed_out || fail_count != 0) begin
      $display("value_noise_fbm test failed");
    end else begin
      $display("value_noise_fbm test passed");
    end
    $finish;
  end
endmodule
